>>> rtl/egru_pkg.sv
package egru_pkg;

    localparam int HIDDEN_MAX  = 64;
    localparam int IDX_W       = 6;
    localparam int DATA_W      = 16;
    localparam int SIZE_W      = 7;
    localparam int SEL_W       = 4;
    localparam int PARAM_COUNT = 9;

    typedef enum logic [1:0] {
        ACT_STEP  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [SEL_W-1:0] SEL_WIR = 4'd0;
    localparam logic [SEL_W-1:0] SEL_WIZ = 4'd1;
    localparam logic [SEL_W-1:0] SEL_WIN = 4'd2;
    localparam logic [SEL_W-1:0] SEL_WHR = 4'd3;
    localparam logic [SEL_W-1:0] SEL_WHZ = 4'd4;
    localparam logic [SEL_W-1:0] SEL_WHN = 4'd5;
    localparam logic [SEL_W-1:0] SEL_BR  = 4'd6;
    localparam logic [SEL_W-1:0] SEL_BZ  = 4'd7;
    localparam logic [SEL_W-1:0] SEL_BN  = 4'd8;

    typedef logic [PARAM_COUNT-1:0][DATA_W-1:0] param_vec_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } hid_wr_t;

    typedef struct packed {
        logic ready;
        logic busy;
        logic hit;
    } pipe_status_t;

    // piecewise sigmoid, signed q13.12 in, 0..4096 out
    function automatic logic [12:0] sig_q(input logic signed [24:0] a);
        logic [24:0] m;
        logic [12:0] y;
        m = a[24] ? 25'(-a) : 25'(a);
        if (m >= 25'd20480) begin
            y = 13'd4096;
        end else if (m >= 25'd9728) begin
            y = 13'(m >> 5) + 13'd3456;
        end else if (m >= 25'd4096) begin
            y = 13'(m >> 3) + 13'd2560;
        end else begin
            y = 13'(m >> 2) + 13'd2048;
        end
        return a[24] ? 13'd4096 - y : y;
    endfunction

endpackage

>>> rtl/egru_param_mem.sv
module egru_param_mem (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [egru_pkg::SEL_W-1:0]          wr_sel,
    input  logic [egru_pkg::IDX_W-1:0]          wr_addr,
    input  logic [egru_pkg::DATA_W-1:0]         wr_data,
    input  logic                                rd_en,
    input  logic [egru_pkg::IDX_W-1:0]          rd_addr,
    output egru_pkg::param_vec_t                rd_data
);

    for (genvar g = 0; g < egru_pkg::PARAM_COUNT; g++) begin : g_bank
        logic [egru_pkg::DATA_W-1:0] mem [egru_pkg::HIDDEN_MAX];
        logic [egru_pkg::DATA_W-1:0] rd_reg;

        always_ff @(posedge aclk) begin
            if (wr_en && wr_sel == egru_pkg::SEL_W'(g)) begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en) begin
                rd_reg <= mem[rd_addr];
            end
        end

        assign rd_data[g] = rd_reg;
    end

endmodule

>>> rtl/egru_hidden_mem.sv
module egru_hidden_mem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  egru_pkg::hid_wr_t           wr,
    input  logic                        rd_en,
    input  logic [egru_pkg::IDX_W-1:0]  rd_addr,
    output logic [egru_pkg::DATA_W-1:0] rd_data
);

    logic [egru_pkg::DATA_W-1:0]     mem [egru_pkg::HIDDEN_MAX];
    logic [egru_pkg::HIDDEN_MAX-1:0] valid_reg;
    logic [egru_pkg::DATA_W-1:0]     rd_data_reg;
    logic                            rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (clear) begin
                valid_reg <= '0;
            end else if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/egru_datapath.sv
module egru_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               st_load,
    input  logic [egru_pkg::IDX_W-1:0]         st_index,
    input  logic signed [egru_pkg::DATA_W-1:0] st_x,
    input  logic                               st_err,
    input  logic [egru_pkg::DATA_W-1:0]        h_rd,
    input  egru_pkg::param_vec_t               p_rd,
    output egru_pkg::pipe_status_t             status,
    output egru_pkg::hid_wr_t                  hid_wr,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [egru_pkg::IDX_W-1:0]         out_index,
    output logic [egru_pkg::DATA_W-1:0]        out_hidden,
    output logic                               out_err
);

    localparam int NS = 9;

    logic [NS:1] v_reg, v_next, go;
    logic        out_v_reg;
    logic [egru_pkg::IDX_W-1:0] idx_reg [1:NS];
    logic                       err_reg [1:NS];

    logic signed [15:0] x1_reg;
    logic signed [15:0] h_s1, wir, wiz, win, whr, whz, whn, br, bz, bn;

    logic signed [31:0] xr2_reg, hr2_reg, xz2_reg, hz2_reg, xn2_reg;
    logic signed [15:0] h2_reg, br2_reg, bz2_reg, bn2_reg, whn2_reg;
    logic signed [21:0] pr3_reg, pz3_reg;
    logic signed [15:0] h3_reg, bn3_reg, whn3_reg;
    logic signed [31:0] xn3_reg;
    logic [12:0]        r4_reg, z4_reg;
    logic signed [15:0] h4_reg, bn4_reg, whn4_reg;
    logic signed [31:0] xn4_reg;
    logic signed [17:0] rh5_reg;
    logic [12:0]        z5_reg;
    logic signed [15:0] h5_reg, bn5_reg, whn5_reg;
    logic signed [31:0] xn5_reg;
    logic signed [33:0] rn6_reg;
    logic [12:0]        z6_reg;
    logic signed [15:0] h6_reg, bn6_reg;
    logic signed [31:0] xn6_reg;
    logic signed [23:0] pn7_reg;
    logic [12:0]        z7_reg;
    logic signed [15:0] h7_reg;
    logic signed [13:0] n8_reg;
    logic [12:0]        z8_reg;
    logic signed [15:0] h8_reg;
    logic signed [29:0] pa9_reg;
    logic signed [27:0] pb9_reg;

    logic [egru_pkg::IDX_W-1:0]  out_idx_reg;
    logic [egru_pkg::DATA_W-1:0] out_h_reg;
    logic                        out_err_reg;

    logic signed [33:0] sum_r, sum_z;
    logic signed [29:0] rh_p;
    logic signed [35:0] sum_n;
    logic [12:0]        sig_n;
    logic signed [13:0] n_next;
    logic signed [30:0] hsum;
    logic signed [18:0] hf;
    logic signed [15:0] hn_next;
    logic               hit;

    assign h_s1 = $signed(h_rd);
    assign wir  = $signed(p_rd[egru_pkg::SEL_WIR]);
    assign wiz  = $signed(p_rd[egru_pkg::SEL_WIZ]);
    assign win  = $signed(p_rd[egru_pkg::SEL_WIN]);
    assign whr  = $signed(p_rd[egru_pkg::SEL_WHR]);
    assign whz  = $signed(p_rd[egru_pkg::SEL_WHZ]);
    assign whn  = $signed(p_rd[egru_pkg::SEL_WHN]);
    assign br   = $signed(p_rd[egru_pkg::SEL_BR]);
    assign bz   = $signed(p_rd[egru_pkg::SEL_BZ]);
    assign bn   = $signed(p_rd[egru_pkg::SEL_BN]);

    // stage advance, collapsing bubbles
    always_comb begin
        go[NS] = v_reg[NS] & (!out_v_reg | out_ready);
        for (int k = NS - 1; k >= 1; k--) begin
            go[k] = v_reg[k] & (!v_reg[k+1] | go[k+1]);
        end
        v_next[1] = st_load | (v_reg[1] & !go[1]);
        for (int k = 2; k <= NS; k++) begin
            v_next[k] = go[k-1] | (v_reg[k] & !go[k]);
        end
        hit = 1'b0;
        for (int k = 1; k <= NS; k++) begin
            hit = hit | (v_reg[k] & (idx_reg[k] == st_index));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end else begin
            v_reg     <= v_next;
            out_v_reg <= go[NS] | (out_v_reg & !out_ready);
        end
    end

    always_comb begin
        sum_r  = 34'(xr2_reg) + 34'(hr2_reg) + (34'(br2_reg) <<< 12);
        sum_z  = 34'(xz2_reg) + 34'(hz2_reg) + (34'(bz2_reg) <<< 12);
        rh_p   = 30'($signed({1'b0, r4_reg})) * 30'(h4_reg);
        sum_n  = 36'(rn6_reg) + 36'(xn6_reg) + (36'(bn6_reg) <<< 12);
        sig_n  = egru_pkg::sig_q({pn7_reg, 1'b0});
        n_next = 14'($signed({1'b0, sig_n, 1'b0}) - 15'sd4096);
        hsum   = 31'(pa9_reg) + 31'(pb9_reg);
        hf     = hsum[30:12];
        if (hf > 19'sd32767) begin
            hn_next = 16'sh7fff;
        end else if (hf < -19'sd32768) begin
            hn_next = -16'sh8000;
        end else begin
            hn_next = hf[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_load) begin
            idx_reg[1] <= st_index;
            err_reg[1] <= st_err;
            x1_reg     <= st_x;
        end
        for (int k = 2; k <= NS; k++) begin
            if (go[k-1]) begin
                idx_reg[k] <= idx_reg[k-1];
                err_reg[k] <= err_reg[k-1];
            end
        end
        if (go[1]) begin
            xr2_reg  <= 32'(x1_reg) * 32'(wir);
            hr2_reg  <= 32'(h_s1) * 32'(whr);
            xz2_reg  <= 32'(x1_reg) * 32'(wiz);
            hz2_reg  <= 32'(h_s1) * 32'(whz);
            xn2_reg  <= 32'(x1_reg) * 32'(win);
            h2_reg   <= h_s1;
            br2_reg  <= br;
            bz2_reg  <= bz;
            bn2_reg  <= bn;
            whn2_reg <= whn;
        end
        if (go[2]) begin
            pr3_reg  <= sum_r[33:12];
            pz3_reg  <= sum_z[33:12];
            h3_reg   <= h2_reg;
            bn3_reg  <= bn2_reg;
            whn3_reg <= whn2_reg;
            xn3_reg  <= xn2_reg;
        end
        if (go[3]) begin
            r4_reg   <= egru_pkg::sig_q(25'(pr3_reg));
            z4_reg   <= egru_pkg::sig_q(25'(pz3_reg));
            h4_reg   <= h3_reg;
            bn4_reg  <= bn3_reg;
            whn4_reg <= whn3_reg;
            xn4_reg  <= xn3_reg;
        end
        if (go[4]) begin
            rh5_reg  <= rh_p[29:12];
            z5_reg   <= z4_reg;
            h5_reg   <= h4_reg;
            bn5_reg  <= bn4_reg;
            whn5_reg <= whn4_reg;
            xn5_reg  <= xn4_reg;
        end
        if (go[5]) begin
            rn6_reg <= 34'(rh5_reg) * 34'(whn5_reg);
            z6_reg  <= z5_reg;
            h6_reg  <= h5_reg;
            bn6_reg <= bn5_reg;
            xn6_reg <= xn5_reg;
        end
        if (go[6]) begin
            pn7_reg <= sum_n[35:12];
            z7_reg  <= z6_reg;
            h7_reg  <= h6_reg;
        end
        if (go[7]) begin
            n8_reg <= n_next;
            z8_reg <= z7_reg;
            h8_reg <= h7_reg;
        end
        if (go[8]) begin
            pa9_reg <= 30'($signed({1'b0, 13'd4096 - z8_reg})) * 30'(h8_reg);
            pb9_reg <= 28'($signed({1'b0, z8_reg})) * 28'(n8_reg);
        end
        if (go[NS]) begin
            out_idx_reg <= idx_reg[NS];
            out_err_reg <= err_reg[NS];
            out_h_reg   <= err_reg[NS] ? '0 : hn_next;
        end
    end

    assign hid_wr.en   = go[NS] & !err_reg[NS];
    assign hid_wr.addr = idx_reg[NS];
    assign hid_wr.data = hn_next;

    assign status.ready = !v_reg[1] | go[1];
    assign status.busy  = |v_reg;
    assign status.hit   = hit;

    assign out_valid  = out_v_reg;
    assign out_index  = out_idx_reg;
    assign out_hidden = out_h_reg;
    assign out_err    = out_err_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && out_err_reg |-> out_h_reg == '0)
        else $error("error item with nonzero hidden value");

    a_wb_last: assert property (@(posedge aclk) disable iff (!aresetn)
        hid_wr.en |=> out_v_reg && !out_err_reg && out_h_reg == $past(hid_wr.data))
        else $error("writeback differs from delivered item");

    a_load_room: assert property (@(posedge aclk) disable iff (!aresetn)
        st_load |-> !v_reg[1] || go[1])
        else $error("stage one overwritten");

    a_load_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        st_load |=> v_reg[1])
        else $error("loaded item lost");

endmodule

>>> rtl/elementwise_gru_cell.sv
// channel   | fields (low bit up)                           | handshake
// s_ item   | tdata: index[5:0] value[21:6]; tuser: action[1:0] param_select[5:2] | tvalid/tready
// m_ item   | tdata: out_index[5:0] hidden_out[21:6]; tuser: index_error | tvalid/tready
// cfg       | cfg_wr_data: active_size                      | cfg_wr_en
//
// a step passes each pipe stage, then the output reg; one item per cycle while m_ does not stall
// a step waits while an earlier step on the same index is in the 9-stage pipe
// a clear waits until the pipe holds no step; writes are always taken
// reset clears all hidden values at once through per-entry valid bits
// stalls on m_ fill the pipe stage by stage before s_tready drops
module elementwise_gru_cell (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // index, value, zero pad
    input  logic [5:0]  s_tuser,   // action, param_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_index, hidden_out, zero pad
    output logic [0:0]  m_tuser    // index_error
);

    logic [egru_pkg::SIZE_W-1:0]  active_size_reg;
    egru_pkg::action_t            action;
    logic [egru_pkg::IDX_W-1:0]   s_index;
    logic [egru_pkg::SEL_W-1:0]   s_sel;
    logic [egru_pkg::DATA_W-1:0]  s_value;
    logic                         accept, step_load, wr_load, clr_load, s_err;
    egru_pkg::pipe_status_t       status;
    egru_pkg::hid_wr_t            hid_wr;
    logic [egru_pkg::DATA_W-1:0]  h_rd;
    egru_pkg::param_vec_t         p_rd;
    logic [egru_pkg::IDX_W-1:0]   out_index;
    logic [egru_pkg::DATA_W-1:0]  out_hidden;
    logic                         out_err;

    assign action  = egru_pkg::action_t'(s_tuser[1:0]);
    assign s_sel   = s_tuser[5:2];
    assign s_index = s_tdata[5:0];
    assign s_value = s_tdata[21:6];
    assign s_err   = {1'b0, s_index} >= active_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_size_reg <= 7'd64;
        end else if (cfg_wr_en) begin
            active_size_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        unique case (action)
            egru_pkg::ACT_STEP:  s_tready = status.ready & !status.hit;
            egru_pkg::ACT_CLEAR: s_tready = !status.busy;
            default:             s_tready = 1'b1;
        endcase
    end

    assign accept    = s_tvalid & s_tready;
    assign step_load = accept & (action == egru_pkg::ACT_STEP);
    assign wr_load   = accept & (action == egru_pkg::ACT_WRITE)
                       & (s_sel <= egru_pkg::SEL_BN);
    assign clr_load  = accept & (action == egru_pkg::ACT_CLEAR);

    egru_param_mem u_param (
        .aclk    (aclk),
        .wr_en   (wr_load),
        .wr_sel  (s_sel),
        .wr_addr (s_index),
        .wr_data (s_value),
        .rd_en   (step_load),
        .rd_addr (s_index),
        .rd_data (p_rd)
    );

    egru_hidden_mem u_hidden (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (clr_load),
        .wr      (hid_wr),
        .rd_en   (step_load),
        .rd_addr (s_index),
        .rd_data (h_rd)
    );

    egru_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .st_load    (step_load),
        .st_index   (s_index),
        .st_x       ($signed(s_value)),
        .st_err     (s_err),
        .h_rd       (h_rd),
        .p_rd       (p_rd),
        .status     (status),
        .hid_wr     (hid_wr),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_index  (out_index),
        .out_hidden (out_hidden),
        .out_err    (out_err)
    );

    assign m_tdata = {2'b00, out_hidden, out_index};
    assign m_tuser = out_err;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = 12;

    typedef struct {
        logic [egru_pkg::IDX_W-1:0]         idx;
        logic signed [egru_pkg::DATA_W-1:0] hid;
        logic                               err;
    } gru_result_t;

    typedef struct {
        egru_pkg::action_t                  act;
        logic [egru_pkg::IDX_W-1:0]         idx;
        logic [egru_pkg::SEL_W-1:0]         sel;
        logic signed [egru_pkg::DATA_W-1:0] val;
        bit                                 typed;
        logic signed [egru_pkg::DATA_W-1:0] hid;
        logic                               err;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [5:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    elementwise_gru_cell u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    gru_result_t hidden_q[$];
    longint      hidden_mem[egru_pkg::HIDDEN_MAX];
    longint      weight_mem[egru_pkg::PARAM_COUNT][egru_pkg::HIDDEN_MAX];
    int unsigned size_limit;
    int          errors;
    int          steps_seen;
    int          errors_seen;
    bit          hold_req;
    bit          burst;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("timeout at %0t", $time);
        $display("[elementwise_gru_cell] ERROR");
        $finish;
    end

    function automatic longint sigm(longint a);
        longint m;
        longint y;
        m = (a < 0) ? -a : a;
        if (m >= 20480) y = 4096;
        else if (m >= 9728) y = (m >>> 5) + 3456;
        else if (m >= 4096) y = (m >>> 3) + 2560;
        else y = (m >>> 2) + 2048;
        return (a < 0) ? 4096 - y : y;
    endfunction

    function automatic longint gate_sum(longint p1, longint p2, longint b);
        return (p1 + p2 + b * 4096) >>> 12;
    endfunction

    function automatic longint pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic predict_item(stim_row_t it);
        gru_result_t e;
        longint x, h, r, z, rh, n, hn;
        int i;
        i = it.idx;
        case (it.act)
            egru_pkg::ACT_WRITE: begin
                if (it.sel < egru_pkg::PARAM_COUNT) begin
                    weight_mem[it.sel][i] = it.val;
                end
            end
            egru_pkg::ACT_CLEAR: begin
                foreach (hidden_mem[k]) hidden_mem[k] = 0;
            end
            egru_pkg::ACT_STEP: begin
                e.idx = it.idx;
                if (i >= size_limit) begin
                    e.hid = '0;
                    e.err = 1'b1;
                end else begin
                    x = it.val;
                    h = hidden_mem[i];
                    r = sigm(gate_sum(x * weight_mem[0][i], h * weight_mem[3][i],
                                      weight_mem[6][i]));
                    z = sigm(gate_sum(x * weight_mem[1][i], h * weight_mem[4][i],
                                      weight_mem[7][i]));
                    rh = (r * h) >>> 12;
                    n = 2 * sigm(2 * gate_sum(x * weight_mem[2][i], rh * weight_mem[5][i],
                                              weight_mem[8][i])) - 4096;
                    hn = ((4096 - z) * h + z * n) >>> 12;
                    if (hn > 32767) hn = 32767;
                    if (hn < -32768) hn = -32768;
                    hidden_mem[i] = hn;
                    e.hid = hn[egru_pkg::DATA_W-1:0];
                    e.err = 1'b0;
                end
                if (it.typed) begin
                    e.hid = it.hid;
                    e.err = it.err;
                end
                hidden_q.push_back(e);
            end
            default: ;
        endcase
    endtask

    task automatic send_item(stim_row_t it);
        longint g;
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, it.val, it.idx};
        s_tuser <= {it.sel, it.act};
        do @(posedge aclk); while (!s_tready);
        predict_item(it);
        @(negedge aclk);
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    task automatic drain_and_config(logic [6:0] sz);
        s_tvalid <= 1'b0;
        while (hidden_q.size() != 0) @(negedge aclk);
        repeat (LATENCY) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= sz;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        size_limit = (sz < egru_pkg::HIDDEN_MAX) ? sz : egru_pkg::HIDDEN_MAX;
    endtask

    function automatic stim_row_t mk(egru_pkg::action_t a, int i, int s, int v);
        stim_row_t it;
        it.act = a;
        it.idx = i[egru_pkg::IDX_W-1:0];
        it.sel = s[egru_pkg::SEL_W-1:0];
        it.val = v[egru_pkg::DATA_W-1:0];
        it.typed = 1'b0;
        it.hid = '0;
        it.err = 1'b0;
        return it;
    endfunction

    function automatic stim_row_t mk_err(int i);
        stim_row_t it;
        it = mk(egru_pkg::ACT_STEP, i, $urandom_range(0, 15), $urandom);
        it.typed = 1'b1;
        it.err = 1'b1;
        return it;
    endfunction

    function automatic stim_row_t rand_item();
        stim_row_t it;
        int unsigned r;
        int i;
        r = $urandom_range(0, 99);
        i = $urandom_range(0, egru_pkg::HIDDEN_MAX - 1);
        if (r < 78) begin
            it = mk(egru_pkg::ACT_STEP, i, $urandom_range(0, 15),
                    ($urandom_range(0, 3) == 0) ? int'($urandom)
                                                : $urandom_range(0, 16383) - 8192);
        end else if (r < 88) begin
            it = mk(egru_pkg::ACT_WRITE, i, $urandom_range(0, egru_pkg::PARAM_COUNT - 1),
                    ($urandom_range(0, 3) == 0) ? int'($urandom)
                                                : $urandom_range(0, 8191) - 4096);
        end else if (r < 93) begin
            it = mk(egru_pkg::ACT_WRITE, i, $urandom_range(egru_pkg::PARAM_COUNT, 15),
                    $urandom);
        end else if (r < 96) begin
            it = mk(egru_pkg::ACT_CLEAR, i, $urandom_range(0, 15), $urandom);
        end else begin
            it = mk(egru_pkg::ACT_NONE, i, $urandom_range(0, 15), $urandom);
        end
        return it;
    endfunction

    always @(posedge aclk) begin
        gru_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (hidden_q.size() == 0) begin
                $display("%0t: unexpected item idx=%0d hid=%0d err=%0d", $time,
                         m_tdata[5:0], $signed(m_tdata[21:6]), m_tuser[0]);
                errors++;
            end else begin
                e = hidden_q.pop_front();
                steps_seen++;
                if (e.err) errors_seen++;
                if (m_tdata[5:0] !== e.idx) begin
                    $display("%0t: out_index expected %0d actual %0d", $time, e.idx,
                             m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[21:6] !== e.hid) begin
                    $display("%0t: hidden_out idx %0d expected %0d actual %0d", $time, e.idx,
                             e.hid, $signed(m_tdata[21:6]));
                    errors++;
                end
                if (m_tuser[0] !== e.err) begin
                    $display("%0t: index_error idx %0d expected %0d actual %0d", $time,
                             e.idx, e.err, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        int hold_cnt;
        longint g;
        m_tready = 1'b0;
        hold_cnt = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_cnt = 300;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0) begin
                m_tready <= 1'b0;
                hold_cnt--;
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    m_tready <= 1'b0;
                    repeat (g - 1) @(negedge aclk);
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        stim_row_t dir_rows[$];
        stim_row_t it;
        logic [6:0] sizes[5];
        errors = 0;
        steps_seen = 0;
        errors_seen = 0;
        hold_req = 1'b0;
        burst = 1'b0;
        size_limit = egru_pkg::HIDDEN_MAX;
        foreach (hidden_mem[k]) hidden_mem[k] = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        drain_and_config(7'd1);
        dir_rows = '{
            mk(egru_pkg::ACT_WRITE, 0, egru_pkg::SEL_WIR, 32767),
            mk(egru_pkg::ACT_WRITE, 0, egru_pkg::SEL_WIZ, -32768),
            mk(egru_pkg::ACT_WRITE, 0, egru_pkg::SEL_WIN, 4096),
            mk(egru_pkg::ACT_WRITE, 0, egru_pkg::SEL_WHR, -4096),
            mk(egru_pkg::ACT_WRITE, 0, egru_pkg::SEL_WHZ, 2048),
            mk(egru_pkg::ACT_WRITE, 0, egru_pkg::SEL_WHN, 32767),
            mk(egru_pkg::ACT_WRITE, 0, egru_pkg::SEL_BR, -32768),
            mk(egru_pkg::ACT_WRITE, 0, egru_pkg::SEL_BZ, 0),
            mk(egru_pkg::ACT_WRITE, 0, egru_pkg::SEL_BN, 1000),
            mk(egru_pkg::ACT_STEP, 0, 0, 32767),
            mk(egru_pkg::ACT_STEP, 0, 15, -32768),
            mk(egru_pkg::ACT_STEP, 0, 0, 0),
            mk_err(63), mk_err(1),
            mk(egru_pkg::ACT_WRITE, 0, 9, 12345),
            mk(egru_pkg::ACT_WRITE, 0, 15, -1),
            mk(egru_pkg::ACT_WRITE, 63, egru_pkg::SEL_BN, -32768),
            mk(egru_pkg::ACT_NONE, 0, 0, 777),
            mk(egru_pkg::ACT_STEP, 0, 0, 4096),
            mk(egru_pkg::ACT_CLEAR, 0, 0, 0),
            mk(egru_pkg::ACT_STEP, 0, 0, -1)
        };
        foreach (dir_rows[k]) send_item(dir_rows[k]);

        drain_and_config(7'd64);
        for (int s = 0; s < egru_pkg::PARAM_COUNT; s++)
            for (int i = 0; i < egru_pkg::HIDDEN_MAX; i++)
                send_item(mk(egru_pkg::ACT_WRITE, i, s, $urandom_range(0, 8191) - 4096));

        sizes = '{7'd64, 7'd1, 7'd127, 7'd37, 7'd64};
        foreach (sizes[p]) begin
            drain_and_config(sizes[p]);
            for (int n = 0; n < 260; n++) begin
                burst = (n >= 200 && n < 240);
                if (p == 2 && n == 100) hold_req = 1'b1;
                it = rand_item();
                send_item(it);
            end
            burst = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (hidden_q.size() != 0) @(negedge aclk);
        repeat (LATENCY) @(negedge aclk);
        $display("covered %0d step results (%0d rejected indices) over several size settings,",
                 steps_seen, errors_seen);
        $display("with parameter writes, bad writes, clears, idle actions and stalls");
        if (errors == 0) begin
            $display("[elementwise_gru_cell] OK");
        end else begin
            $display("[elementwise_gru_cell] ERROR");
        end
        $finish;
    end

endmodule
